// File: src/handheld_memory_map_bus_macros.svh
// Assertion macros for the handheld memory map bus.
// Used by the top level; the bodies expect a clock named clk and reset arst_n.
`ifndef HANDHELD_MEMORY_MAP_BUS_MACROS_SVH
`define HANDHELD_MEMORY_MAP_BUS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define HMMB_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define HMMB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HMMB_ASSERT_IMPLIES(lbl, ante, cons)
`define HMMB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/hmmb_pkg.sv
// Shared types, address map constants and helpers of the memory map bus.
// No dependencies; every other file but the macros header imports it.
package hmmb_pkg;

	// Default store sizes
	localparam int VIDEO_BYTES_DEF    = 8192;
	localparam int EXTERNAL_BYTES_DEF = 8192;
	localparam int BANK_BYTES_DEF     = 4096;
	localparam int ECHO_BYTES_DEF     = 7680;
	localparam int SPRITE_BYTES_DEF   = 160;
	localparam int HIGH_BYTES_DEF     = 127;
	localparam int IO_BYTES           = 128;

	// Address map
	localparam logic [15:0] CART_LAST    = 16'h7FFF;
	localparam logic [15:0] VIDEO_BASE   = 16'h8000;
	localparam logic [15:0] VIDEO_LAST   = 16'h9FFF;
	localparam logic [15:0] EXT_BASE     = 16'hA000;
	localparam logic [15:0] BANK_LO_BASE = 16'hC000;
	localparam logic [15:0] BANK_HI_BASE = 16'hD000;
	localparam logic [15:0] ECHO_BASE    = 16'hE000;
	localparam logic [15:0] ECHO_LAST    = 16'hFDFF;
	localparam logic [15:0] SPRITE_BASE  = 16'hFE00;
	localparam logic [15:0] SPRITE_LAST  = 16'hFE9F;
	localparam logic [15:0] IO_BASE      = 16'hFF00;
	localparam logic [15:0] IO_LAST      = 16'hFF7F;
	localparam logic [15:0] HIGH_BASE    = 16'hFF80;
	localparam logic [15:0] HIGH_LAST    = 16'hFFFE;
	localparam logic [15:0] EXT_LAST     = BANK_LO_BASE - 16'd1;
	localparam logic [15:0] BANK_LO_LAST = BANK_HI_BASE - 16'd1;
	localparam logic [15:0] BANK_HI_LAST = ECHO_BASE - 16'd1;
	localparam logic [15:0] HOLE_LAST    = IO_BASE - 16'd1;

	// Configuration port
	localparam int          PADDR_W         = 2;
	localparam logic [PADDR_W-1:0] REG_STACK_START = 2'd0;
	localparam logic [15:0] STACK_START_RESET = 16'hFFFE;

	typedef enum logic [2:0] {
		REQ_RD_BYTE   = 3'd0,
		REQ_WR_BYTE   = 3'd1,
		REQ_RD_WORD   = 3'd2,
		REQ_WR_WORD   = 3'd3,
		REQ_PUSH_BYTE = 3'd4,
		REQ_POP_BYTE  = 3'd5,
		REQ_PUSH_WORD = 3'd6,
		REQ_POP_WORD  = 3'd7
	} req_kind_t;

	typedef enum logic [3:0] {
		RG_CART, RG_VIDEO, RG_EXT, RG_BANK_LO, RG_BANK_HI, RG_ECHO,
		RG_SPRITE, RG_HOLE, RG_IO, RG_HIGH, RG_IE
	} region_t;

	typedef enum logic [1:0] {
		SRC_ZERO, SRC_CART, SRC_MEM
	} byte_src_t;

	typedef struct packed {
		region_t region;
		logic    hit;
	} dec_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] address;
		logic [15:0] write_value;
		logic [7:0]  cart_byte_low;
		logic [7:0]  cart_byte_high;
	} req_item_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic        cart_write_en;
		logic [14:0] cart_write_addr;
		logic [7:0]  cart_write_byte;
		logic        bad_address;
		logic [15:0] stack_now;
	} rsp_item_t;

	// Total bytes of the unified store, one stretch per region.
	function automatic int mem_depth(int vb, int eb, int bb, int ecb, int sb, int hb);
		return vb + eb + 2 * bb + ecb + sb + IO_BYTES + hb + 1;
	endfunction

endpackage

// File: src/hmmb_if.sv
// Request and response channel interfaces of the memory map bus.
// Depends on hmmb_pkg for the payload types.
interface hmmb_req_if;
	import hmmb_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hmmb_rsp_if;
	import hmmb_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/hmmb_decode.sv
// Address decoder: bus address to region, store hit and unified store index.
// Depends on hmmb_pkg.
module hmmb_decode #(
	parameter int VIDEO_BYTES    = hmmb_pkg::VIDEO_BYTES_DEF,
	parameter int EXTERNAL_BYTES = hmmb_pkg::EXTERNAL_BYTES_DEF,
	parameter int BANK_BYTES     = hmmb_pkg::BANK_BYTES_DEF,
	parameter int ECHO_BYTES     = hmmb_pkg::ECHO_BYTES_DEF,
	parameter int SPRITE_BYTES   = hmmb_pkg::SPRITE_BYTES_DEF,
	parameter int HIGH_BYTES     = hmmb_pkg::HIGH_BYTES_DEF,
	parameter int AW             = 15
) (
	input  logic [15:0]   addr,
	output hmmb_pkg::dec_t dec,
	output logic [AW-1:0] maddr
);
	import hmmb_pkg::*;

	localparam int MB_VIDEO   = 0;
	localparam int MB_EXT     = MB_VIDEO + VIDEO_BYTES;
	localparam int MB_BANK_LO = MB_EXT + EXTERNAL_BYTES;
	localparam int MB_BANK_HI = MB_BANK_LO + BANK_BYTES;
	localparam int MB_ECHO    = MB_BANK_HI + BANK_BYTES;
	localparam int MB_SPRITE  = MB_ECHO + ECHO_BYTES;
	localparam int MB_IO      = MB_SPRITE + SPRITE_BYTES;
	localparam int MB_HIGH    = MB_IO + IO_BYTES;
	localparam int MB_IE      = MB_HIGH + HIGH_BYTES;

	region_t       region;
	logic [15:0]   off;
	logic [AW-1:0] mbase;
	logic          hit;

	always_comb begin
		priority if (addr <= CART_LAST) region = RG_CART;
		else if (addr <= VIDEO_LAST)    region = RG_VIDEO;
		else if (addr <= EXT_LAST)      region = RG_EXT;
		else if (addr <= BANK_LO_LAST)  region = RG_BANK_LO;
		else if (addr <= BANK_HI_LAST)  region = RG_BANK_HI;
		else if (addr <= ECHO_LAST)     region = RG_ECHO;
		else if (addr <= SPRITE_LAST)   region = RG_SPRITE;
		else if (addr <= HOLE_LAST)     region = RG_HOLE;
		else if (addr <= IO_LAST)       region = RG_IO;
		else if (addr <= HIGH_LAST)     region = RG_HIGH;
		else                            region = RG_IE;
	end

	always_comb begin
		off   = '0;
		mbase = '0;
		hit   = 1'b0;
		unique case (region)
			RG_VIDEO: begin
				off   = addr - VIDEO_BASE;
				mbase = AW'(MB_VIDEO);
				hit   = off < 16'(VIDEO_BYTES);
			end
			RG_EXT: begin
				off   = addr - EXT_BASE;
				mbase = AW'(MB_EXT);
				hit   = off < 16'(EXTERNAL_BYTES);
			end
			RG_BANK_LO: begin
				off   = addr - BANK_LO_BASE;
				mbase = AW'(MB_BANK_LO);
				hit   = off < 16'(BANK_BYTES);
			end
			RG_BANK_HI: begin
				off   = addr - BANK_HI_BASE;
				mbase = AW'(MB_BANK_HI);
				hit   = off < 16'(BANK_BYTES);
			end
			RG_ECHO: begin
				off   = addr - ECHO_BASE;
				mbase = AW'(MB_ECHO);
				hit   = off < 16'(ECHO_BYTES);
			end
			RG_SPRITE: begin
				off   = addr - SPRITE_BASE;
				mbase = AW'(MB_SPRITE);
				hit   = off < 16'(SPRITE_BYTES);
			end
			RG_IO: begin
				off   = addr - IO_BASE;
				mbase = AW'(MB_IO);
				hit   = off < 16'(IO_BYTES);
			end
			RG_HIGH: begin
				off   = addr - HIGH_BASE;
				mbase = AW'(MB_HIGH);
				hit   = off < 16'(HIGH_BYTES);
			end
			RG_IE: begin
				mbase = AW'(MB_IE);
				hit   = 1'b1;
			end
			default: begin
				// cartridge and hole never touch the store
				hit = 1'b0;
			end
		endcase
	end

	assign dec.region = region;
	assign dec.hit    = hit;
	assign maddr      = mbase + AW'(off);

endmodule

// File: src/hmmb_mem.sv
// Single-port byte store holding every mapped region but the cartridge; registered read.
// Depends on hmmb_pkg for the default depth.
module hmmb_mem #(
	parameter int DEPTH = hmmb_pkg::mem_depth(hmmb_pkg::VIDEO_BYTES_DEF,
		hmmb_pkg::EXTERNAL_BYTES_DEF, hmmb_pkg::BANK_BYTES_DEF,
		hmmb_pkg::ECHO_BYTES_DEF, hmmb_pkg::SPRITE_BYTES_DEF,
		hmmb_pkg::HIGH_BYTES_DEF),
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);
	import hmmb_pkg::*;

	logic [7:0] store_q [DEPTH];
	logic [7:0] rdata_q;

	// read-first: a write and a read of one address in a cycle return old data
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[addr] <= wdata;
		end
		rdata_q <= store_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/handheld_memory_map_bus.sv
// Top level of the handheld memory map bus: sequencer, stack pointer, APB
// register and response register. Depends on hmmb_pkg, hmmb_if, hmmb_decode,
// hmmb_mem and handheld_memory_map_bus_macros.svh.
`include "handheld_memory_map_bus_macros.svh"

// Byte-wide memory map of a handheld console bus. Each request beat on req is
// a byte or little-endian word read or write, or a byte or word push or pop
// through the stack pointer, and returns exactly one response beat on rsp.
// Video, external, both work banks, echo, sprite, I/O, high RAM and the
// interrupt-enable byte all live in one single-port byte memory
// (VIDEO_BYTES + EXTERNAL_BYTES + 2*BANK_BYTES + ECHO_BYTES + SPRITE_BYTES
// + 128 + HIGH_BYTES + 1 entries, 32672 at the defaults). Cartridge bytes come
// in with the request; a byte write or push to the cartridge comes out as a
// strobe with address and byte in the response. A word write to the
// cartridge does nothing. The hole at 0xFEA0-0xFEFF reads 0, drops writes and
// raises bad_address; a word whose second byte leaves the region of its first
// byte reads 0 for that byte and does not write it.
// Timing: after reset the block sweeps the memory to zero, one entry per
// cycle, and req.ready stays low until every entry is cleared; APB writes
// are taken during the sweep. After that a request uses the memory port
// for its low byte in the accept cycle and its high byte in the next; the
// block can take the next request in the final step of the current one.
// The response beat is registered as the final step ends, raising rsp.valid.
// Stalls on rsp hold the sequencer in its final step, with req.ready low.
// APB: stack_start at byte address 0 (reset 0xFFFE); writing it also loads
// the stack pointer. Write it only while no request is in flight.
module handheld_memory_map_bus #(
	parameter int VIDEO_BYTES    = hmmb_pkg::VIDEO_BYTES_DEF,
	parameter int EXTERNAL_BYTES = hmmb_pkg::EXTERNAL_BYTES_DEF,
	parameter int BANK_BYTES     = hmmb_pkg::BANK_BYTES_DEF,
	parameter int ECHO_BYTES     = hmmb_pkg::ECHO_BYTES_DEF,
	parameter int SPRITE_BYTES   = hmmb_pkg::SPRITE_BYTES_DEF,
	parameter int HIGH_BYTES     = hmmb_pkg::HIGH_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hmmb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	hmmb_req_if.sink                     req,
	hmmb_rsp_if.source                   rsp
);
	import hmmb_pkg::*;

	localparam int DEPTH = mem_depth(VIDEO_BYTES, EXTERNAL_BYTES, BANK_BYTES,
		ECHO_BYTES, SPRITE_BYTES, HIGH_BYTES);
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_HI    = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t        st_q, st_d;
	logic [AW-1:0] clr_q;
	logic [15:0]   stack_start_q;
	logic [15:0]   stack_ptr_q;
	logic          out_valid_q;
	rsp_item_t     out_q, out_d;

	// request decode
	req_kind_t     kind;
	logic          is_word, is_write;
	logic [15:0]   eff_addr, sp_next, hi_addr;
	dec_t          lo_dec, hi_dec;
	logic [AW-1:0] lo_maddr, hi_maddr;
	logic          hi_same;
	byte_src_t     lo_src, hi_src;
	logic          lo_we, hi_we, cart_en;

	// per-request registers
	byte_src_t     lo_src_q, hi_src_q;
	logic          hi_we_q;
	logic [AW-1:0] hi_maddr_q;
	logic [7:0]    wv_hi_q, cart_lo_q, cart_hi_q, lo_byte_q;
	logic          cart_en_q, bad_q;
	logic [14:0]   cart_addr_q;
	logic [7:0]    cart_byte_q;
	logic [15:0]   sp_now_q;

	// memory port
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic [7:0]    mem_wdata, mem_rdata;

	logic          out_free, req_fire, cfg_we;

	function automatic logic [7:0] pick_byte(byte_src_t src, logic [7:0] memb,
		logic [7:0] cartb);
		logic [7:0] b;
		unique case (src)
			SRC_CART: b = cartb;
			SRC_MEM:  b = memb;
			default:  b = 8'd0;
		endcase
		return b;
	endfunction

	// APB register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == REG_STACK_START);
	assign prdata = (paddr == REG_STACK_START) ? {16'd0, stack_start_q} : 32'd0;

	// Handshake: take a request when idle, or in the last step once the
	// response register can take this request's result.
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (st_q == ST_IDLE) || ((st_q == ST_FIN) && out_free);
	assign req_fire  = req.valid && req.ready;

	// Effective address and stack pointer after the request.
	assign kind = req_kind_t'(req.payload.req_type);

	always_comb begin
		eff_addr = req.payload.address;
		sp_next  = stack_ptr_q;
		is_word  = 1'b0;
		is_write = 1'b0;
		unique case (kind)
			REQ_RD_BYTE: begin
			end
			REQ_WR_BYTE: begin
				is_write = 1'b1;
			end
			REQ_RD_WORD: begin
				is_word = 1'b1;
			end
			REQ_WR_WORD: begin
				is_word  = 1'b1;
				is_write = 1'b1;
			end
			REQ_PUSH_BYTE: begin
				is_write = 1'b1;
				eff_addr = stack_ptr_q;
				sp_next  = stack_ptr_q - 16'd1;
			end
			REQ_POP_BYTE: begin
				sp_next  = stack_ptr_q + 16'd1;
				eff_addr = sp_next;
			end
			REQ_PUSH_WORD: begin
				is_word  = 1'b1;
				is_write = 1'b1;
				eff_addr = stack_ptr_q;
				sp_next  = stack_ptr_q - 16'd2;
			end
			REQ_POP_WORD: begin
				is_word  = 1'b1;
				sp_next  = stack_ptr_q + 16'd2;
				eff_addr = sp_next;
			end
		endcase
	end

	assign hi_addr = eff_addr + 16'd1;

	hmmb_decode #(
		.VIDEO_BYTES(VIDEO_BYTES), .EXTERNAL_BYTES(EXTERNAL_BYTES),
		.BANK_BYTES(BANK_BYTES), .ECHO_BYTES(ECHO_BYTES),
		.SPRITE_BYTES(SPRITE_BYTES), .HIGH_BYTES(HIGH_BYTES), .AW(AW)
	) u_dec_lo (
		.addr(eff_addr), .dec(lo_dec), .maddr(lo_maddr)
	);

	hmmb_decode #(
		.VIDEO_BYTES(VIDEO_BYTES), .EXTERNAL_BYTES(EXTERNAL_BYTES),
		.BANK_BYTES(BANK_BYTES), .ECHO_BYTES(ECHO_BYTES),
		.SPRITE_BYTES(SPRITE_BYTES), .HIGH_BYTES(HIGH_BYTES), .AW(AW)
	) u_dec_hi (
		.addr(hi_addr), .dec(hi_dec), .maddr(hi_maddr)
	);

	// The second byte counts only while it stays in the first byte's region;
	// a wrap from the top of the map lands in the cartridge and drops out too.
	assign hi_same = (hi_dec.region == lo_dec.region);

	always_comb begin
		priority if (is_write)               lo_src = SRC_ZERO;
		else if (lo_dec.region == RG_CART)   lo_src = SRC_CART;
		else if (lo_dec.hit)                 lo_src = SRC_MEM;
		else                                 lo_src = SRC_ZERO;

		priority if (is_write || !is_word || !hi_same) hi_src = SRC_ZERO;
		else if (hi_dec.region == RG_CART)             hi_src = SRC_CART;
		else if (hi_dec.hit)                           hi_src = SRC_MEM;
		else                                           hi_src = SRC_ZERO;
	end

	assign lo_we   = is_write && lo_dec.hit;
	assign hi_we   = is_write && is_word && hi_same && hi_dec.hit;
	assign cart_en = is_write && !is_word && (lo_dec.region == RG_CART);

	// Memory port: sweep after reset, low byte in the accept cycle, high byte
	// in the cycle after.
	always_comb begin
		mem_addr  = hi_maddr_q;
		mem_we    = 1'b0;
		mem_wdata = wv_hi_q;
		priority if (st_q == ST_CLEAR) begin
			mem_addr  = clr_q;
			mem_we    = 1'b1;
			mem_wdata = 8'd0;
		end else if (req_fire) begin
			mem_addr  = lo_maddr;
			mem_we    = lo_we;
			mem_wdata = req.payload.write_value[7:0];
		end else if (st_q == ST_HI) begin
			mem_we    = hi_we_q;
		end
	end

	hmmb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .addr(mem_addr), .we(mem_we), .wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Sequencer
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_fire) begin
					st_d = ST_HI;
				end
			end
			ST_HI: begin
				st_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					st_d = req_fire ? ST_HI : ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_CLEAR;
			clr_q         <= '0;
			stack_start_q <= STACK_START_RESET;
			stack_ptr_q   <= STACK_START_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				stack_start_q <= pwdata[15:0];
				stack_ptr_q   <= pwdata[15:0];
			end else if (req_fire) begin
				stack_ptr_q <= sp_next;
			end
			if ((st_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request; hold the low read byte once the memory returns it.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			lo_src_q    <= lo_src;
			hi_src_q    <= hi_src;
			hi_we_q     <= hi_we;
			hi_maddr_q  <= hi_maddr;
			wv_hi_q     <= req.payload.write_value[15:8];
			cart_lo_q   <= req.payload.cart_byte_low;
			cart_hi_q   <= req.payload.cart_byte_high;
			cart_en_q   <= cart_en;
			cart_addr_q <= cart_en ? eff_addr[14:0] : 15'd0;
			cart_byte_q <= cart_en ? req.payload.write_value[7:0] : 8'd0;
			bad_q       <= (lo_dec.region == RG_HOLE);
			sp_now_q    <= sp_next;
		end
		if (st_q == ST_HI) begin
			lo_byte_q <= pick_byte(lo_src_q, mem_rdata, cart_lo_q);
		end
		if ((st_q == ST_FIN) && out_free) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		out_d.read_value      = {pick_byte(hi_src_q, mem_rdata, cart_hi_q), lo_byte_q};
		out_d.cart_write_en   = cart_en_q;
		out_d.cart_write_addr = cart_addr_q;
		out_d.cart_write_byte = cart_byte_q;
		out_d.bad_address     = bad_q;
		out_d.stack_now       = sp_now_q;
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// Checks
	`HMMB_ASSERT_IMPLIES(a_no_accept_in_sweep, st_q == ST_CLEAR, !req.ready)
	`HMMB_ASSERT_NEXT(a_accept_goes_hi, req.valid && req.ready, st_q == ST_HI)
	`HMMB_ASSERT_IMPLIES(a_no_write_in_fin, (st_q == ST_FIN) && !req_fire, !mem_we)
	`HMMB_ASSERT_IMPLIES(a_strobe_clean, rsp.valid && rsp.payload.cart_write_en, rsp.payload.read_value == 16'd0 && !rsp.payload.bad_address)

endmodule
